>>> src/pls_pkg.sv
// shared types and constants for the positional list store
package pls_pkg;

    localparam int CAPACITY   = 16;
    localparam int ELEM_WIDTH = 32;

    localparam int POS_W  = 5;
    localparam int DATA_W = 32;
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 40;

    localparam int S_ACT_LO = 0;
    localparam int S_POS_LO = 2;
    localparam int S_VAL_LO = 7;

    localparam int M_RD_LO    = 0;
    localparam int M_CNT_LO   = 32;
    localparam int M_EMPTY_LO = 37;
    localparam int M_STAT_LO  = 38;

    typedef enum logic [1:0] {
        ACT_READ      = 2'd0,
        ACT_INSERT    = 2'd1,
        ACT_DELETE    = 2'd2,
        ACT_OVERWRITE = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic                  ins;
        logic                  del;
        logic                  wr;
        logic [CMP_W-1:0]      pos;
        logic [ELEM_WIDTH-1:0] val;
    } cell_cmd_t;

endpackage

>>> src/pls_cell.sv
// one storage cell of the shift chain
module pls_cell (
    input  logic                           aclk,
    input  pls_pkg::cell_cmd_t             cmd,
    input  logic [pls_pkg::CMP_W-1:0]      idx,
    input  logic [pls_pkg::ELEM_WIDTH-1:0] left_data,
    input  logic [pls_pkg::ELEM_WIDTH-1:0] right_data,
    output logic [pls_pkg::ELEM_WIDTH-1:0] data,
    output logic [pls_pkg::ELEM_WIDTH-1:0] rd_tap
);
    import pls_pkg::*;

    logic [ELEM_WIDTH-1:0] data_reg;
    logic [ELEM_WIDTH-1:0] data_next;

    always_comb begin
        data_next = data_reg;
        if (cmd.ins) begin
            if (idx > cmd.pos) begin
                data_next = left_data;
            end else if (idx == cmd.pos) begin
                data_next = cmd.val;
            end
        end else if (cmd.del) begin
            if (idx >= cmd.pos) begin
                data_next = right_data;
            end
        end else if (cmd.wr) begin
            if (idx == cmd.pos) begin
                data_next = cmd.val;
            end
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data   = data_reg;
    assign rd_tap = (idx == cmd.pos) ? data_reg : '0;

endmodule

>>> src/pls_ctrl.sv
// operation decode, range checks and element count
module pls_ctrl (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           step,
    input  logic [1:0]                     action,
    input  logic [pls_pkg::POS_W-1:0]      position,
    input  logic [pls_pkg::ELEM_WIDTH-1:0] value,
    output pls_pkg::cell_cmd_t             cmd,
    output logic                           rd_ok,
    output pls_pkg::status_t               status,
    output logic [pls_pkg::CNT_W-1:0]      count_next
);
    import pls_pkg::*;

    logic [CNT_W-1:0] count_reg;
    logic [CMP_W-1:0] pos_ext;
    logic [CMP_W-1:0] cnt_ext;
    logic             ok;
    action_t          act;

    always_comb begin
        act     = action_t'(action);
        pos_ext = CMP_W'(position);
        cnt_ext = CMP_W'(count_reg);
        status  = ST_OK;
        case (act)
            ACT_INSERT: begin
                if (pos_ext > cnt_ext) begin
                    status = ST_RANGE;
                end else if (cnt_ext == CMP_W'(CAPACITY)) begin
                    status = ST_FULL;
                end
            end
            ACT_READ, ACT_DELETE, ACT_OVERWRITE: begin
                if (pos_ext >= cnt_ext) begin
                    status = ST_RANGE;
                end
            end
            default: status = ST_RANGE;
        endcase
        ok      = (status == ST_OK);
        cmd.ins = step && ok && (act == ACT_INSERT);
        cmd.del = step && ok && (act == ACT_DELETE);
        cmd.wr  = step && ok && (act == ACT_OVERWRITE);
        cmd.pos = pos_ext;
        cmd.val = value;
        rd_ok   = ok && (act == ACT_READ);
        count_next = count_reg;
        if (ok && act == ACT_INSERT) begin
            count_next = count_reg + CNT_W'(1);
        end else if (ok && act == ACT_DELETE) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (step) begin
            count_reg <= count_next;
        end
    end

endmodule

>>> src/positional_list_store_unit.sv
// positional list store: chain of shift cells with an output register
// a result is registered and presented in the cycle after its input beat is accepted
// throughput: one beat per cycle unless m_tready stalls the output; affected cells shift in parallel in that cycle
// the output register takes a new result while the previous one is being taken
// reset: synchronous active-low aresetn clears the count and the output valid
// cell contents are not reset and are only read below the count
module positional_list_store_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // action[1:0], position[6:2], value[38:7], zero pad
    input  logic [pls_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // read_value[31:0], element_count[36:32], is_empty[37], status[39:38]
    output logic [pls_pkg::M_TDATA_W-1:0]   m_tdata
);
    import pls_pkg::*;

    logic                  step;
    cell_cmd_t             cmd;
    logic                  rd_ok;
    status_t               status;
    logic [CNT_W-1:0]      count_next;
    logic [ELEM_WIDTH-1:0] cell_data [CAPACITY];
    logic [ELEM_WIDTH-1:0] cell_tap  [CAPACITY];
    logic [ELEM_WIDTH-1:0] rd_any;
    logic [M_TDATA_W-1:0]  result;

    logic                  out_valid_reg;
    logic [M_TDATA_W-1:0]  out_data_reg;

    assign s_tready = !out_valid_reg || m_tready;
    assign step     = s_tvalid && s_tready;

    pls_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (step),
        .action     (s_tdata[S_ACT_LO +: 2]),
        .position   (s_tdata[S_POS_LO +: POS_W]),
        .value      (ELEM_WIDTH'(s_tdata[S_VAL_LO +: DATA_W])),
        .cmd        (cmd),
        .rd_ok      (rd_ok),
        .status     (status),
        .count_next (count_next)
    );

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [ELEM_WIDTH-1:0] left_d;
        logic [ELEM_WIDTH-1:0] right_d;
        if (i == 0) begin : g_first
            assign left_d = '0;
        end else begin : g_mid_l
            assign left_d = cell_data[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign right_d = cell_data[i];
        end else begin : g_mid_r
            assign right_d = cell_data[i+1];
        end
        pls_cell u_cell (
            .aclk       (aclk),
            .cmd        (cmd),
            .idx        (CMP_W'(i)),
            .left_data  (left_d),
            .right_data (right_d),
            .data       (cell_data[i]),
            .rd_tap     (cell_tap[i])
        );
    end

    always_comb begin
        rd_any = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            rd_any = rd_any | cell_tap[k];
        end
        result = '0;
        result[M_RD_LO +: DATA_W]  = rd_ok ? DATA_W'(rd_any) : '0;
        result[M_CNT_LO +: POS_W]  = POS_W'(count_next);
        result[M_EMPTY_LO]         = (count_next == '0);
        result[M_STAT_LO +: 2]     = status;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (step) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            out_data_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

>>> src/pls_checker.sv
// port-level checks for the positional list store, bound to the top level
module pls_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [pls_pkg::M_TDATA_W-1:0] m_tdata
);
    import pls_pkg::*;

    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result beat valid after reset");

    a_accept_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("accepted beat gave no result");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result beat changed");

    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[M_EMPTY_LO] == (m_tdata[M_CNT_LO +: POS_W] == '0))
        else $error("empty flag disagrees with count");

    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[M_STAT_LO +: 2] != ST_OK |-> m_tdata[M_RD_LO +: DATA_W] == '0)
        else $error("rejected beat returned data");

endmodule

bind positional_list_store_unit pls_checker u_pls_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
